// ===== design/assert_macros.svh =====
// Shared assertion macros for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication with no reset qualifier.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ars_pkg.sv =====
`timescale 1ns / 1ps

package ars_pkg;

    // Field widths
    localparam int ALT_W   = 24;
    localparam int SHORT_W = 17;
    localparam int MAIN_W  = 20;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 3;
    localparam int CMP_W   = ALT_W + 1;
    localparam int DIFF_W  = ALT_W + 2;

    // Flight phase codes
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ASCENT  = 3'd1,
        PH_APOGEE  = 3'd2,
        PH_DESCENT = 3'd3,
        PH_MAIN    = 3'd4,
        PH_LANDED  = 3'd5
    } phase_t;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_LAUNCH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DROP    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MAIN    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_LANDING = 3'd3;
    localparam logic [IDX_W-1:0] CFG_REARM   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SHORT_W-1:0] LAUNCH_RST  = 17'd200;
    localparam logic [SHORT_W-1:0] DROP_RST    = 17'd500;
    localparam logic [MAIN_W-1:0]  MAIN_RST    = 20'd50000;
    localparam logic [SHORT_W-1:0] LANDING_RST = 17'd1000;
    localparam logic [SHORT_W-1:0] REARM_RST   = 17'd200;

endpackage

// ===== design/apogee_recovery_sequencer.sv =====
// The result is valid in the cycle after an altitude transfer.
// Throughput: one altitude sample per cycle while the result is not stalled;
// the phase update is a single compare-and-select pass between the state registers and the result.
// A new sample is taken while the result slot is empty or being drained.
// Reset (rst_n low, asynchronous) returns to idle, clears peak and latches,
// and loads the default thresholds.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module apogee_recovery_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ars_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ars_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [ars_pkg::ALT_W-1:0] altitude,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    phase,
    output logic                          apogee_indicator,
    output logic                          drogue_fire,
    output logic                          main_fire
);

    import ars_pkg::*;

    logic [SHORT_W-1:0] launch_reg;
    logic [SHORT_W-1:0] drop_reg;
    logic [MAIN_W-1:0]  main_alt_reg;
    logic [SHORT_W-1:0] landing_reg;
    logic [SHORT_W-1:0] rearm_reg;

    phase_t                   phase_reg, phase_next;
    logic signed [ALT_W-1:0]  peak_reg, peak_next;
    logic                     indicator_reg, indicator_next;
    logic                     drogue_reg, drogue_next;
    logic                     main_reg, main_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     in_xfer;
    logic signed [CMP_W-1:0]  alt_ext;
    logic signed [CMP_W-1:0]  peak_ext;
    logic signed [DIFF_W-1:0] drop_gap;
    logic                     above_launch;
    logic                     above_peak;
    logic                     past_drop;
    logic                     at_main;
    logic                     below_landing;
    logic                     below_rearm;

    // Take a sample when the result slot is free or drains this cycle
    assign in_stall = out_valid_reg & out_stall;
    assign in_xfer  = in_valid & ~in_stall;

    // Threshold compares, signed at one bit above the sample width (the drop gap at two bits above)
    assign alt_ext       = CMP_W'(altitude);
    assign peak_ext      = CMP_W'(peak_reg);
    assign drop_gap      = DIFF_W'(peak_reg) - DIFF_W'(altitude);
    assign above_launch  = alt_ext > $signed({{(CMP_W-SHORT_W){1'b0}}, launch_reg});
    assign above_peak    = alt_ext > peak_ext;
    assign past_drop     = drop_gap > $signed({{(DIFF_W-SHORT_W){1'b0}}, drop_reg});
    assign at_main       = alt_ext <= $signed({{(CMP_W-MAIN_W){1'b0}}, main_alt_reg});
    assign below_landing = alt_ext < $signed({{(CMP_W-SHORT_W){1'b0}}, landing_reg});
    assign below_rearm   = alt_ext < $signed({{(CMP_W-SHORT_W){1'b0}}, rearm_reg});

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (above_launch)
                    phase_next = PH_ASCENT;
            end
            PH_ASCENT:
            begin
                if (!above_peak && past_drop)
                    phase_next = PH_APOGEE;
            end
            PH_APOGEE:  phase_next = PH_DESCENT;
            PH_DESCENT:
            begin
                if (at_main)
                    phase_next = PH_MAIN;
            end
            PH_MAIN:
            begin
                if (below_landing)
                    phase_next = PH_LANDED;
            end
            PH_LANDED:
            begin
                if (below_rearm)
                    phase_next = PH_IDLE;
            end
            default:    phase_next = PH_IDLE;
        endcase
    end

    // Peak tracking and output latches
    always_comb
    begin
        peak_next      = peak_reg;
        indicator_next = indicator_reg;
        drogue_next    = drogue_reg;
        main_next      = main_reg;
        case (phase_reg)
            PH_ASCENT:
            begin
                if (above_peak)
                    peak_next = altitude;
                else if (past_drop)
                    drogue_next = 1'b1;
            end
            PH_APOGEE:  indicator_next = 1'b1;
            PH_DESCENT:
            begin
                if (at_main)
                    main_next = 1'b1;
            end
            PH_LANDED:
            begin
                if (below_rearm)
                begin
                    peak_next      = '0;
                    indicator_next = 1'b0;
                    drogue_next    = 1'b0;
                    main_next      = 1'b0;
                end
            end
            default:    peak_next = peak_reg;
        endcase
    end

    // Hold the result until it is transferred
    always_comb
    begin
        if (in_xfer)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg & out_stall;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg   <= LAUNCH_RST;
            drop_reg     <= DROP_RST;
            main_alt_reg <= MAIN_RST;
            landing_reg  <= LANDING_RST;
            rearm_reg    <= REARM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LAUNCH:  launch_reg   <= cfg_data[SHORT_W-1:0];
                CFG_DROP:    drop_reg     <= cfg_data[SHORT_W-1:0];
                CFG_MAIN:    main_alt_reg <= cfg_data[MAIN_W-1:0];
                CFG_LANDING: landing_reg  <= cfg_data[SHORT_W-1:0];
                CFG_REARM:   rearm_reg    <= cfg_data[SHORT_W-1:0];
                default:     launch_reg   <= launch_reg;
            endcase
        end
    end

    // Advance the sequencer on each sample transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            peak_reg      <= '0;
            indicator_reg <= 1'b0;
            drogue_reg    <= 1'b0;
            main_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                phase_reg     <= phase_next;
                peak_reg      <= peak_next;
                indicator_reg <= indicator_next;
                drogue_reg    <= drogue_next;
                main_reg      <= main_next;
            end
        end
    end

    // The state registers are the result: they change only on a transfer
    assign out_valid        = out_valid_reg;
    assign phase            = phase_reg;
    assign apogee_indicator = indicator_reg;
    assign drogue_fire      = drogue_reg;
    assign main_fire        = main_reg;

    `ASSERT_CLK(a_main_needs_drogue, main_reg |-> drogue_reg, "main fired without drogue")
    `ASSERT_CLK(a_ind_needs_drogue, indicator_reg |-> drogue_reg, "indicator without drogue")
    `ASSERT_CLK(a_idle_clear, (phase_reg == PH_IDLE) |-> (!drogue_reg && !main_reg && !indicator_reg), "latches set while idle")
    `ASSERT_CLK(a_apogee_one_step, (in_xfer && phase_reg == PH_APOGEE) |=> (phase_reg == PH_DESCENT && indicator_reg), "apogee phase did not move to descent")
    `ASSERT_CLK(a_peak_nonneg, !peak_reg[ALT_W-1], "peak altitude went negative")
    `ASSERT_CLK(a_hold_on_stall, in_stall |=> $stable(phase_reg) && $stable(peak_reg), "state changed while result stalled")

endmodule
